FILE: sv/quadrature_counter_rpm_average_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the quadrature speed meter
// Shared shorthand for clocked implication checks with a reset disable.
// ----------------------------------------------------------------------------
`ifndef QUADRATURE_COUNTER_RPM_AVERAGE_MACROS_SVH
`define QUADRATURE_COUNTER_RPM_AVERAGE_MACROS_SVH

// Same-cycle implication.
`define QCRA_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication.
`define QCRA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

FILE: sv/qcra_pkg.sv
// ----------------------------------------------------------------------------
// qcra_pkg
// Types, constants and the microcode program of the quadrature speed meter.
// ----------------------------------------------------------------------------
package qcra_pkg;

    localparam int AVG_DEPTH_DEFAULT = 3;
    localparam int COUNT_W           = 16;
    localparam int RPM_W             = 32;
    localparam int SCALE_W           = 16;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd375;

    localparam int PC_W = 3;
    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t STEP_FETCH    = 3'd0;
    localparam pc_t STEP_MUL      = 3'd1;
    localparam pc_t STEP_STORE    = 3'd2;
    localparam pc_t STEP_ACC      = 3'd3;
    localparam pc_t STEP_DIV_INIT = 3'd4;
    localparam pc_t STEP_DIV      = 3'd5;
    localparam pc_t STEP_EMIT     = 3'd6;

    // Datapath action of one microcode step.
    typedef enum logic [2:0] {
        ACT_FETCH,
        ACT_MUL,
        ACT_STORE,
        ACT_ACC,
        ACT_DIV_INIT,
        ACT_DIV_STEP,
        ACT_EMIT
    } act_t;

    // Sequencing rule of one microcode step.
    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_TICK,
        JMP_LOOP,
        JMP_OUT
    } jmp_t;

    typedef struct packed {
        act_t act;
        jmp_t jmp;
        pc_t  target;
    } ctrl_word_t;

    typedef struct packed {
        logic tick_accept;
        logic loop_last;
        logic out_free;
    } dp_status_t;

    function automatic ctrl_word_t ucode_rom(input pc_t pc);
        ctrl_word_t w;
        case (pc)
            STEP_FETCH:    w = '{act: ACT_FETCH,    jmp: JMP_TICK, target: STEP_FETCH};
            STEP_MUL:      w = '{act: ACT_MUL,      jmp: JMP_NEXT, target: STEP_STORE};
            STEP_STORE:    w = '{act: ACT_STORE,    jmp: JMP_NEXT, target: STEP_ACC};
            STEP_ACC:      w = '{act: ACT_ACC,      jmp: JMP_LOOP, target: STEP_ACC};
            STEP_DIV_INIT: w = '{act: ACT_DIV_INIT, jmp: JMP_NEXT, target: STEP_DIV};
            STEP_DIV:      w = '{act: ACT_DIV_STEP, jmp: JMP_LOOP, target: STEP_DIV};
            STEP_EMIT:     w = '{act: ACT_EMIT,     jmp: JMP_OUT,  target: STEP_FETCH};
            default:       w = '{act: ACT_FETCH,    jmp: JMP_TICK, target: STEP_FETCH};
        endcase
        return w;
    endfunction

endpackage

FILE: sv/quadrature_counter_rpm_average.sv
// ----------------------------------------------------------------------------
// quadrature_counter_rpm_average
// After an edge beat the block stays in its fetch step and is ready again on the next cycle.
// After a tick beat is accepted the microcode runs multiply, store, one
// accumulate step per filled ring entry, divider init, one divide step for each
// of the 32 + clog2(AVG_DEPTH) quotient bits, then emit, which waits on m_ready.
// Reset (aresetn low, synchronous) clears the count, ring pointers, scale to 375.
// ----------------------------------------------------------------------------
module quadrature_counter_rpm_average #(
    parameter int AVG_DEPTH = qcra_pkg::AVG_DEPTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_op,
    input  logic                                s_level_a,
    input  logic                                s_level_b,
    input  logic                                cfg_wr_en,
    input  logic [qcra_pkg::SCALE_W-1:0]        cfg_wr_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [qcra_pkg::COUNT_W-1:0] m_interval_count,
    output logic signed [qcra_pkg::RPM_W-1:0]   m_rpm_mean_q6
);

    qcra_pkg::ctrl_word_t ctrl;
    qcra_pkg::dp_status_t status;

    qcra_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    qcra_dp #(
        .AVG_DEPTH (AVG_DEPTH)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .ctrl             (ctrl),
        .status           (status),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_level_a        (s_level_a),
        .s_level_b        (s_level_b),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_interval_count (m_interval_count),
        .m_rpm_mean_q6    (m_rpm_mean_q6)
    );

endmodule

FILE: sv/qcra_seq.sv
// ----------------------------------------------------------------------------
// qcra_seq
// Step counter and microcode table; issues one control word per cycle.
// ----------------------------------------------------------------------------
module qcra_seq (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  qcra_pkg::dp_status_t   status,
    output qcra_pkg::ctrl_word_t   ctrl
);

    qcra_pkg::pc_t pc_reg;
    qcra_pkg::pc_t pc_next;

    assign ctrl = qcra_pkg::ucode_rom(pc_reg);

    always_comb begin
        pc_next = pc_reg;
        unique case (ctrl.jmp)
            qcra_pkg::JMP_NEXT: pc_next = pc_reg + qcra_pkg::pc_t'(1);
            qcra_pkg::JMP_TICK: begin
                if (status.tick_accept) begin
                    pc_next = pc_reg + qcra_pkg::pc_t'(1);
                end
            end
            qcra_pkg::JMP_LOOP: begin
                pc_next = status.loop_last ? pc_reg + qcra_pkg::pc_t'(1) : ctrl.target;
            end
            qcra_pkg::JMP_OUT: begin
                if (status.out_free) begin
                    pc_next = ctrl.target;
                end
            end
            default: pc_next = qcra_pkg::STEP_FETCH;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= qcra_pkg::STEP_FETCH;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

FILE: sv/qcra_dp.sv
// ----------------------------------------------------------------------------
// qcra_dp
// Datapath: edge counter, scale multiply, averaging ring, serial divider
// and output register, all steered by the microcode control word.
// ----------------------------------------------------------------------------
module qcra_dp #(
    parameter int AVG_DEPTH = qcra_pkg::AVG_DEPTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  qcra_pkg::ctrl_word_t                ctrl,
    output qcra_pkg::dp_status_t                status,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_op,
    input  logic                                s_level_a,
    input  logic                                s_level_b,
    input  logic                                cfg_wr_en,
    input  logic [qcra_pkg::SCALE_W-1:0]        cfg_wr_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [qcra_pkg::COUNT_W-1:0] m_interval_count,
    output logic signed [qcra_pkg::RPM_W-1:0]   m_rpm_mean_q6
);

    localparam int COUNT_W = qcra_pkg::COUNT_W;
    localparam int RPM_W   = qcra_pkg::RPM_W;
    localparam int SCALE_W = qcra_pkg::SCALE_W;
    localparam int PROD_W  = COUNT_W + SCALE_W + 1;
    localparam int SUM_W   = RPM_W + $clog2(AVG_DEPTH);
    localparam int FILL_W  = $clog2(AVG_DEPTH + 1);
    localparam int IDX_W   = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int BIT_W   = $clog2(SUM_W);

    localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(AVG_DEPTH - 1);
    localparam logic [FILL_W-1:0] DEPTH_FILL = FILL_W'(AVG_DEPTH);
    localparam logic [BIT_W-1:0]  LAST_BIT   = BIT_W'(SUM_W - 1);
    localparam logic signed [COUNT_W-1:0] COUNT_MAX = {1'b0, {(COUNT_W-1){1'b1}}};
    localparam logic signed [COUNT_W-1:0] COUNT_MIN = {1'b1, {(COUNT_W-1){1'b0}}};
    localparam logic signed [RPM_W-1:0]   RPM_MAX   = {1'b0, {(RPM_W-1){1'b1}}};
    localparam logic signed [RPM_W-1:0]   RPM_MIN   = {1'b1, {(RPM_W-1){1'b0}}};

    // Control state
    logic [SCALE_W-1:0]        scale_reg;
    logic signed [COUNT_W-1:0] edge_cnt_reg;
    logic signed [COUNT_W-1:0] edge_cnt_next;
    logic [IDX_W-1:0]          wpos_reg;
    logic [FILL_W-1:0]         fill_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic [BIT_W-1:0]          bit_reg;
    logic                      m_valid_reg;
    logic                      m_valid_next;

    // Payload
    logic signed [COUNT_W-1:0] count_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [RPM_W-1:0]   sat_value;
    logic signed [RPM_W-1:0]   ring_reg [AVG_DEPTH];
    logic signed [SUM_W-1:0]   sum_reg;
    logic                      neg_reg;
    logic [SUM_W-1:0]          quo_reg;
    logic [FILL_W:0]           rem_reg;
    logic [FILL_W:0]           trial;
    logic                      qbit;
    logic [SUM_W-1:0]          mean_value;
    logic signed [COUNT_W-1:0] m_interval_count_reg;
    logic signed [RPM_W-1:0]   m_rpm_mean_q6_reg;

    logic accept;
    logic out_free;
    logic loop_last;

    assign s_ready  = (ctrl.act == qcra_pkg::ACT_FETCH);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign status = '{tick_accept: accept && s_op, loop_last: loop_last, out_free: out_free};

    always_comb begin
        case (ctrl.act)
            qcra_pkg::ACT_ACC:      loop_last = (FILL_W'(idx_reg) + FILL_W'(1)) == fill_reg;
            qcra_pkg::ACT_DIV_STEP: loop_last = (bit_reg == LAST_BIT);
            default:                loop_last = 1'b1;
        endcase
    end

    // Saturating up/down count of A-channel edges, cleared by a tick beat.
    always_comb begin
        edge_cnt_next = edge_cnt_reg;
        if (accept) begin
            if (s_op) begin
                edge_cnt_next = '0;
            end else if (s_level_a != s_level_b) begin
                if (edge_cnt_reg != COUNT_MAX) begin
                    edge_cnt_next = edge_cnt_reg + COUNT_W'(1);
                end
            end else begin
                if (edge_cnt_reg != COUNT_MIN) begin
                    edge_cnt_next = edge_cnt_reg - COUNT_W'(1);
                end
            end
        end
    end

    assign prod_next = PROD_W'(count_reg) * PROD_W'($signed({1'b0, scale_reg}));

    // The product leaves the 32-bit range only when its top bits disagree.
    always_comb begin
        if (prod_reg[PROD_W-1:RPM_W-1] == '0 || prod_reg[PROD_W-1:RPM_W-1] == '1) begin
            sat_value = prod_reg[RPM_W-1:0];
        end else begin
            sat_value = prod_reg[PROD_W-1] ? RPM_MIN : RPM_MAX;
        end
    end

    // Restoring division of the sum magnitude by the fill count, one bit a step.
    assign trial = {rem_reg[FILL_W-1:0], quo_reg[SUM_W-1]};
    assign qbit  = (trial >= {1'b0, fill_reg});

    assign mean_value = neg_reg ? (~quo_reg + SUM_W'(1)) : quo_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (ctrl.act == qcra_pkg::ACT_EMIT && out_free) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg    <= qcra_pkg::SCALE_RESET;
            edge_cnt_reg <= '0;
            wpos_reg     <= '0;
            fill_reg     <= '0;
            idx_reg      <= '0;
            bit_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                scale_reg <= cfg_wr_data;
            end
            edge_cnt_reg <= edge_cnt_next;
            m_valid_reg  <= m_valid_next;
            case (ctrl.act)
                qcra_pkg::ACT_STORE: begin
                    wpos_reg <= (wpos_reg == LAST_IDX) ? '0 : wpos_reg + IDX_W'(1);
                    if (fill_reg != DEPTH_FILL) begin
                        fill_reg <= fill_reg + FILL_W'(1);
                    end
                    idx_reg <= '0;
                end
                qcra_pkg::ACT_ACC:      idx_reg <= idx_reg + IDX_W'(1);
                qcra_pkg::ACT_DIV_INIT: bit_reg <= '0;
                qcra_pkg::ACT_DIV_STEP: bit_reg <= bit_reg + BIT_W'(1);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (ctrl.act)
            qcra_pkg::ACT_FETCH: begin
                if (accept && s_op) begin
                    count_reg <= edge_cnt_reg;
                end
            end
            qcra_pkg::ACT_MUL: prod_reg <= prod_next;
            qcra_pkg::ACT_STORE: begin
                ring_reg[wpos_reg] <= sat_value;
                sum_reg            <= '0;
            end
            qcra_pkg::ACT_ACC: sum_reg <= sum_reg + SUM_W'(ring_reg[idx_reg]);
            qcra_pkg::ACT_DIV_INIT: begin
                neg_reg <= sum_reg[SUM_W-1];
                quo_reg <= sum_reg[SUM_W-1] ? (~sum_reg + SUM_W'(1)) : sum_reg;
                rem_reg <= '0;
            end
            qcra_pkg::ACT_DIV_STEP: begin
                rem_reg <= qbit ? (trial - {1'b0, fill_reg}) : trial;
                quo_reg <= {quo_reg[SUM_W-2:0], qbit};
            end
            qcra_pkg::ACT_EMIT: begin
                if (out_free) begin
                    m_interval_count_reg <= count_reg;
                    m_rpm_mean_q6_reg    <= mean_value[RPM_W-1:0];
                end
            end
            default: ;
        endcase
    end

    assign m_valid          = m_valid_reg;
    assign m_interval_count = m_interval_count_reg;
    assign m_rpm_mean_q6    = m_rpm_mean_q6_reg;

endmodule

FILE: sv/qcra_checker.sv
// ----------------------------------------------------------------------------
// qcra_checker
// Port-level checks of the quadrature speed meter, bound to the top level.
// ----------------------------------------------------------------------------
`include "quadrature_counter_rpm_average_macros.svh"

module qcra_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                s_op,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [qcra_pkg::COUNT_W-1:0] m_interval_count,
    input logic signed [qcra_pkg::RPM_W-1:0]   m_rpm_mean_q6
);

    // A stalled result beat keeps its payload.
    `QCRA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
                      m_valid && $stable(m_interval_count) && $stable(m_rpm_mean_q6))

    // An edge beat never produces a result.
    `QCRA_ASSERT_NEXT(a_edge_silent, aclk, aresetn,
                      s_valid && s_ready && !s_op && !m_valid, !m_valid)

    // A tick beat starts the program, so the input side closes at once.
    `QCRA_ASSERT_NEXT(a_tick_busy, aclk, aresetn, s_valid && s_ready && s_op, !s_ready)

    // Results appear only at the end of a program run.
    `QCRA_ASSERT_SAME(a_rise_busy, aclk, aresetn, $rose(m_valid), $past(!s_ready))

endmodule

bind quadrature_counter_rpm_average qcra_checker u_qcra_checker (.*);

FILE: dv/tb_quadrature_counter_rpm_average.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the quadrature speed meter with moving-average output
// Streams encoder edge and sample tick beats through the block, predicts each
// sample result in a cycle-free speed model, and compares every output beat
// against it. Both channels idle at random; the speed scale is changed
// between phases.
// ----------------------------------------------------------------------------
module tb_quadrature_counter_rpm_average;

    localparam int COUNT_W = qcra_pkg::COUNT_W;
    localparam int RPM_W   = qcra_pkg::RPM_W;
    localparam int SCALE_W = qcra_pkg::SCALE_W;

    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam int MEAN_DEPTH     = qcra_pkg::AVG_DEPTH_DEFAULT;
    localparam int IDLE_GUARD     = 64;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PHASE   = 380;

    typedef struct packed {
        logic op;
        logic level_a;
        logic level_b;
    } enc_item_t;

    typedef struct packed {
        logic signed [COUNT_W-1:0] count;
        logic signed [RPM_W-1:0]   mean;
    } speed_result_t;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic                        s_op = 1'b0;
    logic                        s_level_a = 1'b0;
    logic                        s_level_b = 1'b0;
    logic                        cfg_wr_en = 1'b0;
    logic [SCALE_W-1:0]          cfg_wr_data = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic signed [COUNT_W-1:0]   m_interval_count;
    logic signed [RPM_W-1:0]     m_rpm_mean_q6;

    enc_item_t     pending_q[$];
    speed_result_t expected_speed_q[$];
    enc_item_t     drv_item;
    speed_result_t got_speed;
    speed_result_t want_speed;

    // Speed model state.
    logic [SCALE_W-1:0] scale_model = qcra_pkg::SCALE_RESET;
    int                 edge_acc = 0;
    int                 rpm_hist[MEAN_DEPTH];
    int                 hist_wr = 0;
    int                 hist_fill = 0;

    int   items_queued = 0;
    int   items_accepted = 0;
    int   err_cnt = 0;
    int   burst_left = 1;
    int   gap_left = 0;
    int   ready_hold = 0;
    int   idle_cycles = 0;
    logic enc_a = 1'b0;
    logic [15:0] tb_cycle = '0;

    quadrature_counter_rpm_average u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_level_a        (s_level_a),
        .s_level_b        (s_level_b),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_interval_count (m_interval_count),
        .m_rpm_mean_q6    (m_rpm_mean_q6)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        tb_cycle <= tb_cycle + 16'd1;
    end

    // Advances the speed model by one accepted beat; a tick yields one result.
    task automatic update_speed_model(input logic op, input logic a, input logic b);
        longint        prod;
        longint        total;
        speed_result_t res;
        if (op == OP_EDGE) begin
            if (a != b) begin
                if (edge_acc != 32767) edge_acc++;
            end else begin
                if (edge_acc != -32768) edge_acc--;
            end
        end else begin
            prod = longint'(edge_acc) * longint'(scale_model);
            if (prod > 64'sd2147483647) prod = 64'sd2147483647;
            if (prod < -64'sd2147483648) prod = -64'sd2147483648;
            rpm_hist[hist_wr] = int'(prod);
            hist_wr = (hist_wr == MEAN_DEPTH - 1) ? 0 : hist_wr + 1;
            if (hist_fill < MEAN_DEPTH) hist_fill++;
            total = 0;
            for (int i = 0; i < hist_fill; i++) total += longint'(rpm_hist[i]);
            res.count = edge_acc[COUNT_W-1:0];
            res.mean  = RPM_W'(total / longint'(hist_fill));
            expected_speed_q.push_back(res);
            edge_acc = 0;
        end
    endtask

    // Driver: bursts of beats separated by random gaps, with gap-free stretches.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                update_speed_model(s_op, s_level_a, s_level_b);
                items_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    drv_item = pending_q.pop_front();
                    s_valid   <= 1'b1;
                    s_op      <= drv_item.op;
                    s_level_a <= drv_item.level_a;
                    s_level_b <= drv_item.level_b;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        if (tb_cycle[11:10] == 2'b00) gap_left = 0;
                        else if ($urandom_range(0, 3) == 0) gap_left = $urandom_range(5, 30);
                        else gap_left = $urandom_range(0, 3);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result beat and stalls the result channel.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got_speed.count = m_interval_count;
                got_speed.mean  = m_rpm_mean_q6;
                if (expected_speed_q.size() == 0) begin
                    $display("%0t: unexpected result beat count %0d mean %0d", $time,
                             got_speed.count, got_speed.mean);
                    err_cnt++;
                end else begin
                    want_speed = expected_speed_q.pop_front();
                    if (got_speed.count !== want_speed.count) begin
                        $display("%0t: interval_count expected %0d actual %0d", $time,
                                 want_speed.count, got_speed.count);
                        err_cnt++;
                    end
                    if (got_speed.mean !== want_speed.mean) begin
                        $display("%0t: rpm_mean_q6 expected %0d actual %0d", $time,
                                 want_speed.mean, got_speed.mean);
                        err_cnt++;
                    end
                end
            end
            if (ready_hold > 0) begin
                ready_hold--;
            end else if (tb_cycle[9]) begin
                m_ready    <= 1'b1;
                ready_hold = 16;
            end else if ($urandom_range(0, 2) != 0) begin
                m_ready    <= 1'b1;
                ready_hold = $urandom_range(0, 7);
            end else begin
                m_ready    <= 1'b0;
                ready_hold = $urandom_range(0, 24);
            end
        end
    end

    // Watchdog on cycles with no beat moving on either channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, idle_cycles);
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic add_item(input logic op, input logic a, input logic b);
        enc_item_t it;
        it.op      = op;
        it.level_a = a;
        it.level_b = b;
        pending_q.push_back(it);
        items_queued++;
    endtask

    // Channel A toggles on every edge; B sets the direction.
    task automatic push_edge(input logic up);
        enc_a = ~enc_a;
        add_item(OP_EDGE, enc_a, up ? ~enc_a : enc_a);
    endtask

    task automatic push_tick();
        add_item(OP_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // Mostly whole sample intervals with a direction bias, plus some noise.
    task automatic queue_random_motion(input int n);
        int start;
        int kind;
        int len;
        int bias;
        start = items_queued;
        while (items_queued - start < n) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                add_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
            end else if (kind == 9) begin
                repeat ($urandom_range(2, 4)) push_tick();
            end else begin
                len  = (kind == 8) ? $urandom_range(0, 300) : $urandom_range(0, 24);
                bias = $urandom_range(0, 100);
                repeat (len) push_edge($urandom_range(0, 99) < bias);
                push_tick();
            end
        end
    endtask

    // Waits until all beats are in and all results out, then lets the block settle.
    task automatic wait_drained();
        while (items_accepted != items_queued || expected_speed_q.size() != 0)
            @(posedge aclk);
        repeat (IDLE_GUARD) @(posedge aclk);
    endtask

    task automatic write_scale(input logic [SCALE_W-1:0] v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        scale_model = v;
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset scale: empty interval, both directions,
        // all four level pairs, the ring wrapping, and ignored levels on a tick.
        push_tick();
        add_item(OP_EDGE, 1'b1, 1'b0);
        push_tick();
        add_item(OP_EDGE, 1'b0, 1'b0);
        add_item(OP_EDGE, 1'b1, 1'b1);
        add_item(OP_EDGE, 1'b0, 1'b0);
        push_tick();
        add_item(OP_EDGE, 1'b0, 1'b1);
        add_item(OP_EDGE, 1'b1, 1'b0);
        add_item(OP_EDGE, 1'b0, 1'b1);
        push_tick();
        push_tick();
        add_item(OP_TICK, 1'b1, 1'b1);
        add_item(OP_TICK, 1'b0, 1'b0);
        wait_drained();

        write_scale(16'd0);
        queue_random_motion(RANDOM_PHASE);
        wait_drained();

        write_scale(16'd1);
        queue_random_motion(RANDOM_PHASE);
        wait_drained();

        write_scale(SCALE_W'($urandom_range(2, 65534)));
        queue_random_motion(RANDOM_PHASE);
        wait_drained();

        write_scale(qcra_pkg::SCALE_RESET);
        queue_random_motion(RANDOM_PHASE);
        wait_drained();

        write_scale(16'hFFFF);
        queue_random_motion(RANDOM_PHASE);
        wait_drained();

        if (expected_speed_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_speed_q.size());
            err_cnt++;
        end
        if (err_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/qcra_pkg.sv
sv/qcra_seq.sv
sv/qcra_dp.sv
sv/quadrature_counter_rpm_average.sv
sv/qcra_checker.sv
dv/tb_quadrature_counter_rpm_average.sv
